// ===== sv/cdeq_pkg.sv =====
// ----------------------------------------------------------------------------
// cdeq_pkg
// Shared types and constants of the circular double-ended queue.
// ----------------------------------------------------------------------------
`default_nettype none

package cdeq_pkg;

   // Store geometry
   localparam int DEPTH  = 1024;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int DATA_W = 32;

   // Register and field widths fixed by the interface
   localparam int CAP_W  = 11;
   localparam int OCC_W  = 11;
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;

   localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

   // Register index (byte address / 4)
   localparam logic CSR_IDX_CAPACITY = 1'b0;

   typedef enum logic [1:0] {
      ACT_PUSH_HEAD = 2'd0,
      ACT_PUSH_TAIL = 2'd1,
      ACT_POP_HEAD  = 2'd2,
      ACT_POP_TAIL  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // Store access and result info of one item, from the pointer unit
   typedef struct packed {
      logic              en;
      logic              we;
      logic [ADDR_W-1:0] addr;
      logic              pop_ok;
      status_type        status;
      logic [CNT_W-1:0]  occupancy;
   } ptr_cmd_type;

endpackage

`default_nettype wire

// ===== sv/circular_double_ended_queue_core.sv =====
// ----------------------------------------------------------------------------
// circular_double_ended_queue_core
// Double-ended queue of 32-bit words in a circular on-chip store.
// ----------------------------------------------------------------------------
// Each request item pushes a word at the head or tail, or pops one from the
// head or tail, and yields exactly one response item: the popped word (0 on
// pushes and on failed pops), a status (done, pop on empty, push on full -
// a push into a full queue is dropped, nothing is overwritten), the occupancy
// after the item and an empty flag. The capacity register (byte address 0,
// reset 1024, 0 reads as 1 in use, values above the store depth clamp to it)
// sets where the head and tail wrap; any write to it empties the queue.
// Write it only while no items are in flight. One item is taken per cycle
// unless the request side is stalled; each item does its pointer update and
// store access as it enters stage 1, then moves with the store's registered
// read data into the response register. Throughput is set by the single
// store port, which every item uses at most once. Backpressure on the
// response side stalls the request side only when both stages are full.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_double_ended_queue_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request stream
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [31:0]                   req_tdata,   // [31:0] push_value
   input  wire logic [1:0]                    req_tuser,   // [1:0] action
   // response stream
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic      [47:0]                   rsp_tdata,   // [31:0] pop_value,
                                                           // [42:32] occupancy
   output logic      [2:0]                    rsp_tuser,   // [1:0] status,
                                                           // [2] is_empty
   // register port
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [cdeq_pkg::CSR_AW-1:0]   csr_paddr,
   input  wire logic [cdeq_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic      [cdeq_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                               csr_pready
);

   localparam int CW = cdeq_pkg::CNT_W;
   localparam int DW = cdeq_pkg::DATA_W;

   // ---------------------------------------------------------------- CSR
   logic [cdeq_pkg::CAP_W-1:0] cap_ff;
   logic                       cap_wr;
   logic [31:0]                cap_wide;
   logic [CW-1:0]              cap_eff;

   assign csr_pready = 1'b1;
   assign cap_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == cdeq_pkg::CSR_IDX_CAPACITY);
   assign csr_prdata = (csr_paddr[2] == cdeq_pkg::CSR_IDX_CAPACITY)
                       ? cdeq_pkg::CSR_DW'(cap_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= cdeq_pkg::CAP_RESET;
      end else if (cap_wr) begin
         cap_ff <= csr_pwdata[cdeq_pkg::CAP_W-1:0];
      end
   end

   // clamp to 1..DEPTH
   assign cap_wide = 32'(cap_ff);
   always_comb begin
      if (cap_wide == 32'd0) begin
         cap_eff = CW'(1);
      end else if (cap_wide > 32'(cdeq_pkg::DEPTH)) begin
         cap_eff = CW'(cdeq_pkg::DEPTH);
      end else begin
         cap_eff = CW'(cap_wide);
      end
   end

   // ---------------------------------------------------------------- stages
   // stage 1: item has touched the store, read data due from the RAM
   logic                  s1_valid_ff;
   logic                  s1_pop_ok_ff;
   cdeq_pkg::status_type  s1_status_ff;
   logic [CW-1:0]         s1_occ_ff;
   logic                  s1_move;
   logic                  req_acc;

   // response register
   logic                  rsp_valid_ff;
   logic [DW-1:0]         rsp_pop_ff;
   cdeq_pkg::status_type  rsp_status_ff;
   logic [cdeq_pkg::OCC_W-1:0] rsp_occ_ff;

   cdeq_pkg::ptr_cmd_type cmd;
   logic [DW-1:0]         ram_rdata;

   assign s1_move    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_move;
   assign req_acc    = req_tvalid && req_tready;

   cdeq_ptr u_ptr (
      .clock    (clock),
      .reset    (reset),
      .op_valid (req_acc),
      .action   (cdeq_pkg::action_type'(req_tuser)),
      .clear    (cap_wr),
      .cap_eff  (cap_eff),
      .cmd      (cmd)
   );

   // RAM read data holds while stage 1 stalls: no new access without accept
   cdeq_ram #(
      .WIDTH (DW),
      .DEPTH (cdeq_pkg::DEPTH)
   ) u_ram (
      .clock (clock),
      .en    (req_acc && cmd.en),
      .we    (cmd.we),
      .addr  (cmd.addr),
      .wdata (req_tdata),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_pop_ok_ff <= cmd.pop_ok;
         s1_status_ff <= cmd.status;
         s1_occ_ff    <= cmd.occupancy;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_move) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_pop_ff    <= s1_pop_ok_ff ? ram_rdata : '0;
         rsp_status_ff <= s1_status_ff;
         rsp_occ_ff    <= cdeq_pkg::OCC_W'(s1_occ_ff);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_occ_ff, rsp_pop_ff};
   assign rsp_tuser  = {(rsp_occ_ff == '0), rsp_status_ff};

endmodule

`default_nettype wire

// ===== sv/cdeq_ram.sv =====
// ----------------------------------------------------------------------------
// cdeq_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cdeq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                             clock,
   input  wire logic                             en,
   input  wire logic                             we,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] addr,
   input  wire logic [WIDTH-1:0]                 wdata,
   output logic      [WIDTH-1:0]                 rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== sv/cdeq_ptr.sv =====
// ----------------------------------------------------------------------------
// cdeq_ptr
// Head, tail and fill count of the queue; picks the store entry per item.
// ----------------------------------------------------------------------------
`default_nettype none

module cdeq_ptr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          op_valid,
   input  wire cdeq_pkg::action_type          action,
   input  wire logic                          clear,
   input  wire logic [cdeq_pkg::CNT_W-1:0]    cap_eff,
   output cdeq_pkg::ptr_cmd_type              cmd
);

   localparam int AW = cdeq_pkg::ADDR_W;
   localparam int CW = cdeq_pkg::CNT_W;

   logic [AW-1:0] head_ff, head_in;
   logic [AW-1:0] tail_ff, tail_in;
   logic [CW-1:0] fill_ff, fill_in;

   logic [AW-1:0] head_inc, head_dec, tail_inc, tail_dec;
   logic [AW-1:0] cap_last;
   logic          full, empty;

   assign cap_last = AW'(cap_eff - CW'(1));
   assign full     = (fill_ff >= cap_eff);
   assign empty    = (fill_ff == '0);

   // wrap at the effective capacity
   assign head_inc = (CW'(head_ff) + CW'(1) >= cap_eff) ? '0 : AW'(head_ff + AW'(1));
   assign tail_inc = (CW'(tail_ff) + CW'(1) >= cap_eff) ? '0 : AW'(tail_ff + AW'(1));
   assign head_dec = (head_ff == '0 || CW'(head_ff) >= cap_eff) ? cap_last
                                                              : AW'(head_ff - AW'(1));
   assign tail_dec = (tail_ff == '0 || CW'(tail_ff) >= cap_eff) ? cap_last
                                                              : AW'(tail_ff - AW'(1));

   always_comb begin
      head_in        = head_ff;
      tail_in        = tail_ff;
      fill_in        = fill_ff;
      cmd.en         = 1'b0;
      cmd.we         = 1'b0;
      cmd.addr       = head_ff;
      cmd.pop_ok     = 1'b0;
      cmd.status     = cdeq_pkg::ST_DONE;
      case (action)
         cdeq_pkg::ACT_PUSH_HEAD: begin
            if (full) begin
               cmd.status = cdeq_pkg::ST_FULL;
            end else begin
               head_in  = head_dec;
               cmd.en   = 1'b1;
               cmd.we   = 1'b1;
               cmd.addr = head_dec;
               fill_in  = CW'(fill_ff + CW'(1));
            end
         end
         cdeq_pkg::ACT_PUSH_TAIL: begin
            if (full) begin
               cmd.status = cdeq_pkg::ST_FULL;
            end else begin
               tail_in  = tail_inc;
               cmd.en   = 1'b1;
               cmd.we   = 1'b1;
               cmd.addr = tail_ff;
               fill_in  = CW'(fill_ff + CW'(1));
            end
         end
         cdeq_pkg::ACT_POP_HEAD: begin
            if (empty) begin
               cmd.status = cdeq_pkg::ST_EMPTY;
            end else begin
               head_in    = head_inc;
               cmd.en     = 1'b1;
               cmd.addr   = head_ff;
               cmd.pop_ok = 1'b1;
               fill_in    = CW'(fill_ff - CW'(1));
            end
         end
         cdeq_pkg::ACT_POP_TAIL: begin
            if (empty) begin
               cmd.status = cdeq_pkg::ST_EMPTY;
            end else begin
               tail_in    = tail_dec;
               cmd.en     = 1'b1;
               cmd.addr   = tail_dec;
               cmd.pop_ok = 1'b1;
               fill_in    = CW'(fill_ff - CW'(1));
            end
         end
         default: begin
            cmd.status = cdeq_pkg::ST_DONE;
         end
      endcase
      cmd.occupancy = fill_in;
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         head_ff <= '0;
         tail_ff <= '0;
         fill_ff <= '0;
      end else if (op_valid) begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         fill_ff <= fill_in;
      end
   end

endmodule

`default_nettype wire

// ===== dv/tb_circular_double_ended_queue_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_circular_double_ended_queue_core
// Self-checking bench for the circular double-ended queue core.
// ----------------------------------------------------------------------------
// Request items (push/pop at either end) are queued by the sequence block and
// sent by a clocked driver with random gaps; every accepted item runs through
// a shadow deque that predicts the response. A clocked monitor pulls
// responses with random stalls, including one long hold-off that backs the
// core up, and compares each field against the oldest prediction. Capacity
// is reprogrammed between phases (0, 1, small, 1024, 2047 and random) while
// the core is idle, and a write to an unused address checks it is ignored.
// ----------------------------------------------------------------------------

module tb_circular_double_ended_queue_core;
   import cdeq_pkg::*;

   localparam int          LONG_HOLD    = 300;  // cycles of receiver hold-off
   localparam int          DRAIN_CYCLES = 8;    // settle time before a capacity write and at the end
   localparam logic [2:0]  ADDR_CAP     = 3'd0; // capacity register
   localparam logic [2:0]  ADDR_SPARE   = 3'd4; // no register here

   typedef struct {
      action_type  action;
      logic [31:0] word;
   } req_item_t;

   typedef struct {
      logic [31:0]      pop_value;
      status_type       status;
      logic [OCC_W-1:0] occupancy;
      logic             is_empty;
   } rsp_item_t;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;
   always #5 clock = ~clock;

   // block inputs, known from time zero
   logic                req_tvalid  = 1'b0;
   logic [31:0]         req_tdata   = '0;   // [31:0] push_value
   logic [1:0]          req_tuser   = '0;   // [1:0] action
   logic                rsp_tready  = 1'b0;
   logic                csr_psel    = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite  = 1'b0;
   logic [CSR_AW-1:0]   csr_paddr   = '0;
   logic [CSR_DW-1:0]   csr_pwdata  = '0;

   // block outputs
   logic                req_tready;
   logic                rsp_tvalid;
   logic [47:0]         rsp_tdata;        // [31:0] pop_value, [42:32] occupancy
   logic [2:0]          rsp_tuser;        // [1:0] status, [2] is_empty
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;

   circular_double_ended_queue_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // stimulus and expectation stores
   req_item_t   pending_req[$];
   rsp_item_t   expected_rsp[$];

   // shadow copy of the deque
   logic [31:0]       shadow_store [DEPTH];
   logic [ADDR_W-1:0] shadow_head = '0;
   logic [ADDR_W-1:0] shadow_tail = '0;
   logic [CNT_W-1:0]  shadow_fill = '0;
   logic [CAP_W-1:0]  shadow_cap  = CAP_RESET;

   // pacing controls, written by the sequence block at a falling edge
   bit steady     = 1'b0;   // no gaps on either side while set
   int hold_asked = 0;      // long hold-offs requested
   int hold_done  = 0;      // long hold-offs started by the monitor

   // bookkeeping
   int errors      = 0;
   int accepted    = 0;
   int checked     = 0;
   int full_drops  = 0;
   int empty_pops  = 0;
   int cap_writes  = 0;

   // driver/monitor local state
   int        send_gap   = 0;
   int        stall_left = 0;
   int        hold_left  = 0;
   req_item_t next_req;

   // ------------------------------------------------------------------------
   // Shadow deque
   // ------------------------------------------------------------------------

   // capacity as the core uses it: 0 acts as 1, anything above DEPTH clamps
   function automatic logic [CAP_W-1:0] usable_cap();
      logic [CAP_W-1:0] c;
      c = shadow_cap;
      if (c == 0) c = CAP_W'(1);
      if (c > DEPTH) c = CAP_W'(DEPTH);
      return c;
   endfunction

   function automatic logic [ADDR_W-1:0] wrap_inc(input logic [ADDR_W-1:0] p,
                                                  input logic [CAP_W-1:0]  cap);
      if (({1'b0, p} + 1'b1) >= cap) return '0;
      return p + 1'b1;
   endfunction

   function automatic logic [ADDR_W-1:0] wrap_dec(input logic [ADDR_W-1:0] p,
                                                  input logic [CAP_W-1:0]  cap);
      logic [CAP_W-1:0] last;
      last = cap - 1'b1;
      if (p == 0 || {1'b0, p} >= cap) return last[ADDR_W-1:0];
      return p - 1'b1;
   endfunction

   // apply one accepted request to the shadow deque, queue its response
   function automatic void deque_predict(input action_type act,
                                         input logic [31:0] word);
      logic [CAP_W-1:0] cap;
      rsp_item_t        r;
      cap = usable_cap();
      r.pop_value = '0;
      r.status    = ST_DONE;
      case (act)
         ACT_PUSH_HEAD, ACT_PUSH_TAIL: begin
            if (shadow_fill >= cap) begin
               // full: dropped, nothing overwritten
               r.status = ST_FULL;
               full_drops++;
            end else if (act == ACT_PUSH_HEAD) begin
               shadow_head = wrap_dec(shadow_head, cap);
               shadow_store[shadow_head] = word;
               shadow_fill++;
            end else begin
               shadow_store[shadow_tail] = word;
               shadow_tail = wrap_inc(shadow_tail, cap);
               shadow_fill++;
            end
         end
         default: begin
            if (shadow_fill == 0) begin
               r.status = ST_EMPTY;
               empty_pops++;
            end else if (act == ACT_POP_HEAD) begin
               r.pop_value = shadow_store[shadow_head];
               shadow_head = wrap_inc(shadow_head, cap);
               shadow_fill--;
            end else begin
               shadow_tail = wrap_dec(shadow_tail, cap);
               r.pop_value = shadow_store[shadow_tail];
               shadow_fill--;
            end
         end
      endcase
      r.occupancy = shadow_fill;
      r.is_empty  = (shadow_fill == 0);
      expected_rsp.push_back(r);
   endfunction

   // gap length: mostly none or short, now and then long
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(11, 30);
   endfunction

   // ------------------------------------------------------------------------
   // Driver: sends pending items, predicts on each accept
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            deque_predict(action_type'(req_tuser), req_tdata);
            accepted++;
         end
         // only move on when the current item is gone (or there is none)
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_req.size() > 0) begin
               next_req = pending_req.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= next_req.word;
               req_tuser  <= next_req.action;
               send_gap = steady ? 0 : idle_len();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: random stalls, long hold-off on request, field checks
   // ------------------------------------------------------------------------
   task automatic check_response();
      rsp_item_t exp;
      if (expected_rsp.size() == 0) begin
         $error("response item with no prediction waiting: tdata %h tuser %h",
                rsp_tdata, rsp_tuser);
         errors++;
      end else begin
         exp = expected_rsp.pop_front();
         checked++;
         if (rsp_tdata[31:0] !== exp.pop_value) begin
            $error("pop_value expected %h actual %h", exp.pop_value, rsp_tdata[31:0]);
            errors++;
         end
         if (rsp_tuser[1:0] !== exp.status) begin
            $error("status expected %0d actual %0d", exp.status, rsp_tuser[1:0]);
            errors++;
         end
         if (rsp_tdata[42:32] !== exp.occupancy) begin
            $error("occupancy expected %0d actual %0d", exp.occupancy, rsp_tdata[42:32]);
            errors++;
         end
         if (rsp_tuser[2] !== exp.is_empty) begin
            $error("is_empty expected %0b actual %0b", exp.is_empty, rsp_tuser[2]);
            errors++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_response();
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (hold_done < hold_asked) begin
            // long hold-off: the core fills both stages and stalls requests
            hold_done++;
            hold_left = LONG_HOLD;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            stall_left = (steady || $urandom_range(0, 3) != 0) ? 0 : idle_len();
         end
      end
   end

   // ------------------------------------------------------------------------
   // Sequence helpers
   // ------------------------------------------------------------------------
   task automatic add_item(input action_type act, input logic [31:0] word);
      req_item_t it;
      it.action = act;
      it.word   = word;
      pending_req.push_back(it);
   endtask

   // n random items, push_pct percent of them pushes; pops carry junk words
   task automatic queue_mix(input int n, input int push_pct);
      action_type act;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 99) < push_pct)
            act = $urandom_range(0, 1) ? ACT_PUSH_TAIL : ACT_PUSH_HEAD;
         else
            act = $urandom_range(0, 1) ? ACT_POP_TAIL : ACT_POP_HEAD;
         add_item(act, $urandom);
      end
   endtask

   // random phase: runs that lean to filling, to draining, or neither,
   // so small capacities hit both full and empty over and over
   task automatic run_phase(input int n);
      int left;
      int seg;
      int bias;
      left = n;
      while (left > 0) begin
         seg = $urandom_range(4, 32);
         if (seg > left) seg = left;
         case ($urandom_range(0, 2))
            0:       bias = 15;
            1:       bias = 50;
            default: bias = 85;
         endcase
         queue_mix(seg, bias);
         left -= seg;
      end
   endtask

   // sequence pauses here until every item is sent and every prediction matched
   task automatic wait_drained();
      @(negedge clock);
      while (pending_req.size() != 0 || req_tvalid || expected_rsp.size() != 0)
         @(negedge clock);
   endtask

   task automatic set_pace(input bit no_gaps);
      @(negedge clock);
      steady = no_gaps;
   endtask

   // register write, setup then access phase; called only while the core is idle
   task automatic csr_write(input logic [CSR_AW-1:0] addr, input logic [CSR_DW-1:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      // only index 0 exists; a capacity write empties the queue
      if (addr[CSR_AW-1:2] == CSR_IDX_CAPACITY) begin
         shadow_cap  = data[CAP_W-1:0];
         shadow_head = '0;
         shadow_tail = '0;
         shadow_fill = '0;
         cap_writes++;
      end
   endtask

   task automatic new_capacity(input logic [CAP_W-1:0] cap);
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_write(ADDR_CAP, {{(CSR_DW-CAP_W){1'b0}}, cap});
      // address still points at the capacity register: read it back
      @(negedge clock);
      if (csr_pready !== 1'b1) begin
         $error("pready expected 1 actual %b", csr_pready);
         errors++;
      end
      if (csr_prdata !== {{(CSR_DW-CAP_W){1'b0}}, cap}) begin
         $error("capacity readback expected %0d actual %0d", cap, csr_prdata);
         errors++;
      end
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed, reset capacity (1024): empty pops, extreme words, both ends
      add_item(ACT_POP_HEAD,  $urandom);
      add_item(ACT_POP_TAIL,  $urandom);
      add_item(ACT_PUSH_HEAD, 32'h8000_0000);   // head wraps below index 0
      add_item(ACT_PUSH_TAIL, 32'h7FFF_FFFF);
      add_item(ACT_PUSH_HEAD, 32'hFFFF_FFFF);
      add_item(ACT_PUSH_TAIL, 32'h0000_0000);
      add_item(ACT_PUSH_HEAD, 32'h5555_5555);
      add_item(ACT_PUSH_TAIL, 32'hAAAA_AAAA);
      add_item(ACT_POP_HEAD,  $urandom);
      add_item(ACT_POP_TAIL,  $urandom);
      add_item(ACT_POP_HEAD,  $urandom);
      add_item(ACT_POP_TAIL,  $urandom);
      add_item(ACT_POP_HEAD,  $urandom);
      add_item(ACT_POP_TAIL,  $urandom);
      add_item(ACT_POP_HEAD,  $urandom);        // empty again
      add_item(ACT_PUSH_TAIL, 32'h0000_0001);
      add_item(ACT_POP_HEAD,  $urandom);

      // capacity 1: one word fills it, further pushes are dropped
      new_capacity(11'd1);
      add_item(ACT_PUSH_HEAD, $urandom);
      add_item(ACT_PUSH_TAIL, $urandom);
      add_item(ACT_PUSH_HEAD, $urandom);
      add_item(ACT_POP_TAIL,  $urandom);
      add_item(ACT_POP_HEAD,  $urandom);

      // capacity 0 behaves as 1
      new_capacity(11'd0);
      run_phase(50);

      // 2047 clamps to the full store: fill it under a long receiver hold-off
      new_capacity(11'd2047);
      @(negedge clock);
      hold_asked++;
      queue_mix(DEPTH + 6, 100);
      queue_mix(40, 50);
      queue_mix(60, 0);

      new_capacity(11'd2);
      run_phase(60);

      // back-to-back with no gaps on either side
      new_capacity(11'd3);
      set_pace(1'b1);
      run_phase(60);
      wait_drained();
      set_pace(1'b0);

      // a write to the unused address must not touch the queue
      new_capacity(11'd5);
      run_phase(30);
      wait_drained();
      csr_write(ADDR_SPARE, $urandom);
      run_phase(35);

      new_capacity(11'd8);
      run_phase(60);

      new_capacity(11'd16);
      set_pace(1'b1);
      run_phase(60);
      wait_drained();
      set_pace(1'b0);

      new_capacity(11'($urandom_range(1, 40)));
      run_phase(60);

      new_capacity(11'($urandom_range(1, 40)));
      run_phase(60);

      new_capacity(11'd1);
      run_phase(40);

      new_capacity(11'($urandom_range(0, 2047)));
      run_phase(60);

      new_capacity(11'd1024);
      run_phase(60);

      // wind down
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_rsp.size() != 0) begin
         $error("%0d predicted responses never arrived", expected_rsp.size());
         errors++;
      end
      $display("Run covered %0d request items and %0d checked responses",
               accepted, checked);
      $display("over %0d capacity settings; full-queue drops: %0d, empty-queue pops: %0d",
               cap_writes + 1, full_drops, empty_pops);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("Timeout: core stopped making progress");
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== files.f =====
sv/cdeq_pkg.sv
sv/cdeq_ram.sv
sv/cdeq_ptr.sv
sv/circular_double_ended_queue_core.sv
dv/tb_circular_double_ended_queue_core.sv
